[rtl/assert_macros.svh]
// Assertion helpers shared by the grid walk lookup files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[rtl/gwwl_pkg.sv]
// ----------------------------------------------------------------------------
// gwwl_pkg
// Shared types and constants of the grid walk weight lookup unit.
// ----------------------------------------------------------------------------
package gwwl_pkg;
    localparam int TableEntriesDef = 256;
    localparam int WalkPointsDef   = 3;
    localparam int OneQ16          = 65536;
    localparam int SpeedScale      = 10000000;
    localparam int SpeedFloor      = 65536;

    localparam logic [1:0] StOk       = 2'd0;
    localparam logic [1:0] StNotFound = 2'd1;
    localparam logic [1:0] StFull     = 2'd2;
    localparam logic [1:0] StSat      = 2'd3;

    localparam logic [1:0] RegNx   = 2'd0;
    localparam logic [1:0] RegNy   = 2'd1;
    localparam logic [1:0] RegNz   = 2'd2;
    localparam logic [1:0] RegArea = 2'd3;

    // One classified request passed from the front to the back.
    typedef struct packed {
        logic        is_query;
        logic [47:0] key;
        logic [31:0] weight;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
    } t_req;
endpackage

[rtl/gwwl_front.sv]
// ----------------------------------------------------------------------------
// gwwl_front
// Accepts requests, packs load keys and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module gwwl_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_opcode,
    input  logic [15:0]     i_key_x,
    input  logic [15:0]     i_key_y,
    input  logic [15:0]     i_key_z,
    input  logic [31:0]     i_weight_value,
    input  logic [31:0]     i_pos_x,
    input  logic [31:0]     i_pos_y,
    input  logic [31:0]     i_pos_z,
    output logic            o_full,
    output logic            o_empty,
    output gwwl_pkg::t_req  o_req,
    input  logic            i_pop
);
    import gwwl_pkg::*;
    t_req       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       push;
    t_req       w_in;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign push    = i_start && !o_full;
    assign o_req   = r_q[r_rp];

    always_comb begin
        w_in.is_query = i_opcode;
        w_in.key      = {i_key_x, i_key_y, i_key_z};
        w_in.weight   = i_weight_value;
        w_in.pos_x    = i_pos_x;
        w_in.pos_y    = i_pos_y;
        w_in.pos_z    = i_pos_z;
        n_cnt = r_cnt + {1'b0, push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= n_cnt;
        end
        if (push) r_q[r_wp] <= w_in;
    end

`include "assert_macros.svh"
    `ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, i_pop, !o_empty, "pop from empty queue")
    `ASSERT_NXT(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt != 2'd3, "queue count overflow")
    `ASSERT_NXT(a_push_cnt, i_clk, i_rst_n, push && !i_pop, r_cnt == $past(r_cnt) + 2'd1,
        "push lost")
endmodule

[rtl/gwwl_div.sv]
// ----------------------------------------------------------------------------
// gwwl_div
// Restoring divider, one quotient bit per cycle, 49-bit dividend.
// ----------------------------------------------------------------------------
module gwwl_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [48:0] i_num,
    input  logic [32:0] i_den,
    output logic        o_done,
    output logic [48:0] o_quo
);
    logic [48:0] r_q;
    logic [33:0] r_rem;
    logic [32:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [33:0] sh;

    assign sh    = {r_rem[32:0], r_q[48]};
    assign o_quo = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd49;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
        if (i_go) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            if (sh >= {1'b0, r_den}) begin
                r_rem <= sh - {1'b0, r_den};
                r_q   <= {r_q[47:0], 1'b1};
            end else begin
                r_rem <= sh;
                r_q   <= {r_q[47:0], 1'b0};
            end
        end
    end
endmodule

[rtl/gwwl_back.sv]
// ----------------------------------------------------------------------------
// gwwl_back
// Carries out loads and queries: table scan, lattice walk and divide.
// ----------------------------------------------------------------------------
module gwwl_back #(
    parameter int TABLE_ENTRIES = gwwl_pkg::TableEntriesDef,
    parameter int WALK_POINTS   = gwwl_pkg::WalkPointsDef
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  gwwl_pkg::t_req  i_req,
    output logic            o_pop,
    input  logic [17:0]     i_nx,
    input  logic [17:0]     i_ny,
    input  logic [17:0]     i_nz,
    input  logic [31:0]     i_area,
    output logic            o_done,
    output logic [31:0]     o_scale,
    output logic [1:0]      o_status
);
    import gwwl_pkg::*;
    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int KW = (WALK_POINTS > 1) ? $clog2(WALK_POINTS) : 1;

    localparam logic [3:0] S_IDLE = 4'd0, S_PREP = 4'd1, S_SCAN = 4'd2, S_CHK = 4'd3,
                           S_MUL = 4'd4, S_CMP = 4'd5, S_DIV = 4'd6, S_DWAIT = 4'd7,
                           S_OUT = 4'd8, S_RDW = 4'd9;

    logic [47:0] r_keys [TABLE_ENTRIES];
    logic [31:0] r_wts  [TABLE_ENTRIES];
    logic [47:0] r_rkey;
    logic [31:0] r_rwt;
    logic [CW-1:0] r_fill;
    logic [CW-1:0] r_idx;
    logic [3:0]  r_st;
    t_req        r_req;
    logic [47:0] r_tkey;
    logic        r_rdv;
    logic [AW-1:0] r_hidx;
    logic [KW-1:0] r_k;
    logic signed [33:0] r_lat [3];
    logic [31:0] r_dist [3];
    logic [17:0] r_mag  [3];
    logic [49:0] r_p01, r_p10, r_p02, r_p20, r_p12, r_p21;
    logic        r_go;
    logic [31:0] r_wq;
    logic        div_done;
    logic [48:0] div_quo;
    logic [1:0]  c;
    logic        in_lat;
    logic        e01, e02, e12;
    logic [17:0] nv [3];
    logic [31:0] pv [3];

    // Crossing order of two axes. Distances stay below 2^21, so an axis with a
    // zero component (floor speed) loses to any moving axis and only races
    // another zero axis on distance alone.
    function automatic logic earlier(input logic [17:0] mi, input logic [17:0] mj,
                                     input logic [31:0] di, input logic [31:0] dj,
                                     input logic [49:0] pij, input logic [49:0] pji);
        if (mi == 18'd0) return (mj == 18'd0) && (di < dj);
        if (mj == 18'd0) return 1'b1;
        return pij < pji;
    endfunction

    assign nv[0] = i_nx; assign nv[1] = i_ny; assign nv[2] = i_nz;
    assign pv[0] = r_req.pos_x; assign pv[1] = r_req.pos_y; assign pv[2] = r_req.pos_z;
    assign o_pop = (r_st == S_IDLE) && !i_empty;

    always_comb begin
        in_lat = 1'b1;
        for (int i = 0; i < 3; i++)
            if (r_lat[i] < -34'sd32768 || r_lat[i] > 34'sd32767) in_lat = 1'b0;
        e01 = earlier(r_mag[0], r_mag[1], r_dist[0], r_dist[1], r_p01, r_p10);
        e02 = earlier(r_mag[0], r_mag[2], r_dist[0], r_dist[2], r_p02, r_p20);
        e12 = earlier(r_mag[1], r_mag[2], r_dist[1], r_dist[2], r_p12, r_p21);
        if (e01) begin
            if (e02) c = 2'd0;
            else if (e12) c = 2'd1;
            else c = 2'd2;
        end else begin
            c = e12 ? 2'd1 : 2'd2;
        end
    end

    gwwl_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(r_go),
        .i_num({1'b0, i_area, 16'd0} + {17'd0, r_wq}),
        .i_den({r_wq, 1'b0}), .o_done(div_done), .o_quo(div_quo)
    );

    always_ff @(posedge i_clk) begin
        r_rkey <= r_keys[r_idx[AW-1:0]];
        r_rwt  <= r_wts[r_hidx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_fill <= '0;
            o_done <= 1'b0;
            r_go   <= 1'b0;
        end else begin
            o_done <= 1'b0;
            r_go   <= 1'b0;
            unique case (r_st)
                S_IDLE: if (!i_empty) begin
                    r_req <= i_req;
                    r_st  <= S_PREP;
                end
                S_PREP: begin
                    // set up the walk or the load key, then scan the table
                    r_k <= '0;
                    if (r_req.is_query) begin
                        for (int i = 0; i < 3; i++) begin
                            if (nv[i][17]) begin
                                r_lat[i]  <= {{18{pv[i][31]}}, pv[i][31:16]};
                                r_dist[i] <= {16'd0, pv[i][15:0]} + 32'(OneQ16);
                                r_mag[i]  <= 18'(-nv[i]);
                            end else begin
                                r_lat[i]  <= {{18{pv[i][31]}}, pv[i][31:16]}
                                             + 34'(pv[i][15:0] != 16'd0);
                                r_dist[i] <= (pv[i][15:0] == 16'd0) ? 32'(OneQ16)
                                             : 32'(2 * OneQ16) - {16'd0, pv[i][15:0]};
                                r_mag[i]  <= nv[i];
                            end
                        end
                        r_st <= S_CHK;
                    end else begin
                        r_tkey <= r_req.key;
                        r_idx  <= '0;
                        r_rdv  <= 1'b0;
                        r_st   <= S_SCAN;
                    end
                end
                S_CHK: begin
                    // look up the current lattice point or step on
                    if (in_lat) begin
                        r_tkey <= {r_lat[0][15:0], r_lat[1][15:0], r_lat[2][15:0]};
                        r_idx  <= '0;
                        r_rdv  <= 1'b0;
                        r_st   <= S_SCAN;
                    end else r_st <= S_MUL;
                end
                S_SCAN: begin
                    // each entry is read into a register and compared before the next is read
                    r_rdv <= 1'b0;
                    if (r_rdv && r_rkey == r_tkey) begin
                        r_hidx <= AW'(r_idx - CW'(1));
                        r_st  <= r_req.is_query ? S_RDW : S_OUT;
                    end else if (r_idx < r_fill && !r_rdv) begin
                        r_rdv <= 1'b1;
                        r_idx <= r_idx + CW'(1);
                    end else if (r_idx >= r_fill && !r_rdv) begin
                        if (r_req.is_query) r_st <= S_MUL;
                        else begin
                            if (r_fill < CW'(TABLE_ENTRIES)) begin
                                r_keys[r_fill[AW-1:0]] <= r_req.key;
                                r_wts[r_fill[AW-1:0]]  <= r_req.weight;
                                r_fill <= r_fill + CW'(1);
                                o_status <= StOk;
                            end else o_status <= StFull;
                            o_scale <= '0;
                            o_done <= 1'b1;
                            r_st <= S_IDLE;
                        end
                    end
                end
                S_RDW: begin
                    // wait here for the registered weight read
                    r_st <= S_DIV;
                end
                S_MUL: begin
                    if (32'(r_k) + 1 >= WALK_POINTS) begin
                        o_scale <= '0;
                        o_status <= StNotFound;
                        o_done <= 1'b1;
                        r_st <= S_IDLE;
                    end else begin
                        r_p01 <= r_dist[0] * r_mag[1];
                        r_p10 <= r_dist[1] * r_mag[0];
                        r_p02 <= r_dist[0] * r_mag[2];
                        r_p20 <= r_dist[2] * r_mag[0];
                        r_p12 <= r_dist[1] * r_mag[2];
                        r_p21 <= r_dist[2] * r_mag[1];
                        r_st <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_lat[c]  <= nv[c][17] ? r_lat[c] - 34'sd1 : r_lat[c] + 34'sd1;
                    r_dist[c] <= r_dist[c] + 32'(OneQ16);
                    r_k <= r_k + KW'(1);
                    r_st <= S_CHK;
                end
                S_OUT: begin
                    // overwrite on a load hit
                    r_wts[r_hidx] <= r_req.weight;
                    o_scale <= '0;
                    o_status <= StOk;
                    o_done <= 1'b1;
                    r_st <= S_IDLE;
                end
                S_DIV: begin
                    r_st <= S_DWAIT;
                    if (r_rwt == 32'd0) begin
                        o_scale <= '1;
                        o_status <= StSat;
                        o_done <= 1'b1;
                        r_st <= S_IDLE;
                    end else begin
                        r_wq <= r_rwt;
                        r_go <= 1'b1;
                    end
                end
                S_DWAIT: if (div_done) begin
                    if (div_quo[48:32] != 17'd0) begin
                        o_scale <= '1;
                        o_status <= StSat;
                    end else begin
                        o_scale <= div_quo[31:0];
                        o_status <= StOk;
                    end
                    o_done <= 1'b1;
                    r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

`include "assert_macros.svh"
    `ASSERT_NXT(a_done_pulse, i_clk, i_rst_n, o_done, !o_done, "result held two cycles")
    `ASSERT_IMP(a_done_idle, i_clk, i_rst_n, o_done, r_st == S_IDLE, "result outside idle")
    `ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= CW'(TABLE_ENTRIES),
        "fill count past depth")
endmodule

[rtl/grid_walk_weight_lookup_unit.sv]
// ----------------------------------------------------------------------------
// grid_walk_weight_lookup_unit
// Weight table keyed by lattice points, with a walk along the iolet normal.
// ----------------------------------------------------------------------------
// Channel   Direction  Signals
// request   in         i_start/o_busy, i_opcode, i_key_*, i_weight_value, i_pos_*
// result    out        o_done, o_scale, o_status
// config    in         psel/penable/pwrite/paddr/pwdata, prdata, pready
//
// The table scan reads each entry into a register, then compares it, before
// it reads the next. A load strobes o_done after its scan. A query scans the
// table for each walk point inside the 16-bit lattice, and a hit adds the
// divider wait before the strobe.
// Synchronous active-low reset clears queue and fill count, presets registers.
// o_busy rises only when the two-entry request queue is full; the receiver
// cannot stall, each result is a one-cycle strobe on o_done.
// ----------------------------------------------------------------------------
module grid_walk_weight_lookup_unit #(
    parameter int TABLE_ENTRIES = gwwl_pkg::TableEntriesDef,
    parameter int WALK_POINTS   = gwwl_pkg::WalkPointsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_opcode,
    input  logic [15:0] i_key_x,
    input  logic [15:0] i_key_y,
    input  logic [15:0] i_key_z,
    input  logic [31:0] i_weight_value,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    output logic        o_done,
    output logic [31:0] o_scale,
    output logic [1:0]  o_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gwwl_pkg::*;
    logic [17:0] r_nx, r_ny, r_nz;
    logic [31:0] r_area;
    logic        empty, pop, wr;
    t_req        req;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    // register file, word addresses
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nx <= 18'd65536;
            r_ny <= '0;
            r_nz <= '0;
            r_area <= 32'd65536;
        end else if (wr && paddr[1:0] == 2'b00) begin
            unique case (paddr[3:2])
                RegNx:   r_nx <= pwdata[17:0];
                RegNy:   r_ny <= pwdata[17:0];
                RegNz:   r_nz <= pwdata[17:0];
                RegArea: r_area <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            RegNx:   prdata = {{14{r_nx[17]}}, r_nx};
            RegNy:   prdata = {{14{r_ny[17]}}, r_ny};
            RegNz:   prdata = {{14{r_nz[17]}}, r_nz};
            RegArea: prdata = r_area;
        endcase
    end

    gwwl_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_opcode(i_opcode),
        .i_key_x(i_key_x), .i_key_y(i_key_y), .i_key_z(i_key_z),
        .i_weight_value(i_weight_value), .i_pos_x(i_pos_x), .i_pos_y(i_pos_y),
        .i_pos_z(i_pos_z), .o_full(o_busy), .o_empty(empty), .o_req(req), .i_pop(pop)
    );

    gwwl_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .WALK_POINTS(WALK_POINTS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(empty), .i_req(req), .o_pop(pop),
        .i_nx(r_nx), .i_ny(r_ny), .i_nz(r_nz), .i_area(r_area),
        .o_done(o_done), .o_scale(o_scale), .o_status(o_status)
    );
endmodule

[bench/grid_walk_weight_lookup_unit_tb.sv]
// ----------------------------------------------------------------------------
// grid_walk_weight_lookup_unit_tb
// Loads lattice weights, queries positions along several normals and areas,
// and checks every result against a typed answer or a built-in table and walk model.
// ----------------------------------------------------------------------------
module grid_walk_weight_lookup_unit_tb;
    import gwwl_pkg::*;

    localparam logic OpLoad  = 1'b0;
    localparam logic OpQuery = 1'b1;
    localparam int   IdleLimit = 20000;
    localparam int   DrainCycles = 100;

    typedef struct packed {
        logic        op;
        logic [15:0] kx;
        logic [15:0] ky;
        logic [15:0] kz;
        logic [31:0] w;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
    } t_request;

    typedef struct packed {
        logic [31:0] scale;
        logic [1:0]  st;
    } t_answer;

    // Directed row: a request plus an optional typed answer.
    typedef struct packed {
        t_request    req;
        logic        typed;
        t_answer     ans;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic        i_opcode;
    logic [15:0] i_key_x, i_key_y, i_key_z;
    logic [31:0] i_weight_value;
    logic [31:0] i_pos_x, i_pos_y, i_pos_z;
    logic        o_done;
    logic [31:0] o_scale;
    logic [1:0]  o_status;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    grid_walk_weight_lookup_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_opcode(i_opcode), .i_key_x(i_key_x), .i_key_y(i_key_y), .i_key_z(i_key_z),
        .i_weight_value(i_weight_value), .i_pos_x(i_pos_x), .i_pos_y(i_pos_y),
        .i_pos_z(i_pos_z), .o_done(o_done), .o_scale(o_scale),
        .o_status(o_status), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // Shadow copy of the weight table and the config registers.
    logic [47:0]        tbl_key [TableEntriesDef];
    logic [31:0]        tbl_wt  [TableEntriesDef];
    int                 tbl_fill;
    logic signed [17:0] norm [3];
    logic [31:0]        area;

    t_answer answers_due [$];
    int      errors;
    int      idle_cycles;
    logic    req_taken;

    function automatic int lookup_key(input logic [47:0] key);
        for (int i = 0; i < tbl_fill; i++)
            if (tbl_key[i] == key) return i;
        return -1;
    endfunction

    // Compare crossing times of two axes exactly by cross multiplication.
    function automatic logic crosses_first(input longint unsigned d[3],
                                           input longint unsigned s[3],
                                           input int a, input int b);
        return d[a] * s[b] < d[b] * s[a];
    endfunction

    // Work out the answer to one request and apply its table update.
    function automatic t_answer predict_answer(input t_request r);
        t_answer           res;
        logic [31:0]       pos [3];
        longint            lat [3];
        longint            dir [3];
        longint unsigned   dst [3];
        longint unsigned   spd [3];
        longint            p, n, frac, mag;
        longint unsigned   wt, q;
        logic [47:0]       key;
        int                hit, ax;
        logic              in_range;
        res = '0;
        if (r.op == OpLoad) begin
            key = {r.kx, r.ky, r.kz};
            hit = lookup_key(key);
            res.st = StOk;
            if (hit >= 0) begin
                tbl_wt[hit] = r.w;
            end else if (tbl_fill < TableEntriesDef) begin
                tbl_key[tbl_fill] = key;
                tbl_wt[tbl_fill]  = r.w;
                tbl_fill++;
            end else begin
                res.st = StFull;
            end
            return res;
        end
        pos[0] = r.px; pos[1] = r.py; pos[2] = r.pz;
        for (int i = 0; i < 3; i++) begin
            p    = longint'(signed'(pos[i]));
            n    = longint'(norm[i]);
            frac = p & 64'hFFFF;
            mag  = (n < 0) ? -n : n;
            spd[i] = (mag == 0) ? SpeedFloor : longint'(mag) * SpeedScale;
            if (n < 0) begin
                dir[i]  = -1;
                lat[i]  = (p - frac) >>> 16;
                dst[i] = frac + OneQ16;
            end else begin
                dir[i]  = 1;
                lat[i]  = ((p - frac) >>> 16) + ((frac != 0) ? 1 : 0);
                dst[i] = 2 * OneQ16 - ((frac == 0) ? OneQ16 : frac);
            end
        end
        for (int k = 0; k < WalkPointsDef; k++) begin
            in_range = 1'b1;
            for (int i = 0; i < 3; i++)
                if (lat[i] < -32768 || lat[i] > 32767) in_range = 1'b0;
            if (in_range) begin
                hit = lookup_key({lat[0][15:0], lat[1][15:0], lat[2][15:0]});
                if (hit >= 0) begin
                    wt = tbl_wt[hit];
                    if (wt == 0) begin
                        res.scale = '1;
                        res.st    = StSat;
                        return res;
                    end
                    q = ((longint'(area) << 16) + wt) / (2 * wt);
                    if (q > 64'hFFFF_FFFF) begin
                        res.scale = '1;
                        res.st    = StSat;
                    end else begin
                        res.scale = q[31:0];
                        res.st    = StOk;
                    end
                    return res;
                end
            end
            if (k + 1 == WalkPointsDef) break;
            // Step the axis whose next plane comes first; ties go to the higher axis.
            if (crosses_first(dst, spd, 0, 1))
                ax = crosses_first(dst, spd, 0, 2) ? 0 :
                     (crosses_first(dst, spd, 1, 2) ? 1 : 2);
            else
                ax = crosses_first(dst, spd, 1, 2) ? 1 : 2;
            lat[ax]  += dir[ax];
            dst[ax] += OneQ16;
        end
        res.scale = '0;
        res.st    = StNotFound;
        return res;
    endfunction

    // Check each result strobe against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (answers_due.size() == 0) begin
                $display("%0t: unexpected result scale=%h status=%0d",
                         $time, o_scale, o_status);
                errors++;
            end else begin
                if (o_scale !== answers_due[0].scale) begin
                    $display("%0t: scale expected %h actual %h",
                             $time, answers_due[0].scale, o_scale);
                    errors++;
                end
                if (o_status !== answers_due[0].st) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, answers_due[0].st, o_status);
                    errors++;
                end
                void'(answers_due.pop_front());
            end
        end
    end

    // Watchdog: end the run if neither a request nor a result moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || req_taken || o_done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    always @(posedge i_clk) req_taken <= i_start && !o_busy;

    // Register write: setup, then access held until pready completes it.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            RegNx:   norm[0] = val[17:0];
            RegNy:   norm[1] = val[17:0];
            RegNz:   norm[2] = val[17:0];
            default: area    = val;
        endcase
    endtask

    task automatic set_config(input int nx, input int ny, input int nz,
                              input logic [31:0] ar);
        write_reg(RegNx, nx);
        write_reg(RegNy, ny);
        write_reg(RegNz, nz);
        write_reg(RegArea, ar);
        @(posedge i_clk);
    endtask

    // Hold until every expected result is back, then let the block settle.
    task automatic drain_results();
        i_start <= 1'b0;
        do @(posedge i_clk); while (answers_due.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    // Present one request and hold it until the edge that accepts it.
    task automatic send_request(input t_request r, input logic typed, input t_answer ans);
        t_answer guess;
        i_start        <= 1'b1;
        i_opcode       <= r.op;
        i_key_x        <= r.kx;
        i_key_y        <= r.ky;
        i_key_z        <= r.kz;
        i_weight_value <= r.w;
        i_pos_x        <= r.px;
        i_pos_y        <= r.py;
        i_pos_z        <= r.pz;
        do @(posedge i_clk); while (o_busy);
        guess = predict_answer(r);
        answers_due = {answers_due, (typed ? ans : guess)};
    endtask

    function automatic logic [15:0] pick_key();
        if ($urandom_range(0, 99) < 85) return 16'(int'($urandom_range(0, 8)) - 4);
        return 16'($urandom);
    endfunction

    function automatic logic [31:0] pick_pos();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return 32'((int'($urandom_range(0, 8)) - 4) * OneQ16 +
                       int'($urandom_range(0, 131071)) - OneQ16);
        if (r < 85)
            return 32'((int'($urandom_range(0, 8)) - 4) * OneQ16);
        return $urandom;
    endfunction

    function automatic t_request random_request();
        t_request r;
        int       pick;
        r.op = ($urandom_range(0, 99) < 45) ? OpLoad : OpQuery;
        r.kx = pick_key();
        r.ky = pick_key();
        r.kz = pick_key();
        pick = $urandom_range(0, 15);
        if (pick == 0)      r.w = '0;
        else if (pick < 4)  r.w = $urandom_range(1, 255);
        else if (pick < 10) r.w = $urandom_range(1, 32'h0004_0000);
        else                r.w = $urandom;
        r.px = pick_pos();
        r.py = pick_pos();
        r.pz = pick_pos();
        return r;
    endfunction

    function automatic t_row mk_row(input logic op, input int kx, input int ky, input int kz,
                                    input logic [31:0] w, input logic [31:0] px,
                                    input logic [31:0] py, input logic [31:0] pz,
                                    input logic typed, input logic [31:0] sc,
                                    input logic [1:0] st);
        t_row row;
        row.req   = '{op, 16'(kx), 16'(ky), 16'(kz), w, px, py, pz};
        row.typed = typed;
        row.ans   = '{sc, st};
        return row;
    endfunction

    t_row    dir_rows [$];
    t_answer no_ans;
    int      burst, phase_items;

    initial begin
        errors      = 0;
        tbl_fill    = 0;
        norm[0]     = 18'sd65536;
        norm[1]     = '0;
        norm[2]     = '0;
        area        = 32'h0001_0000;
        no_ans      = '0;
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_opcode    = 1'b0;
        i_key_x     = '0;
        i_key_y     = '0;
        i_key_z     = '0;
        i_weight_value = '0;
        i_pos_x     = '0;
        i_pos_y     = '0;
        i_pos_z     = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        req_taken   = 1'b0;
        idle_cycles = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with the reset normal (+x) and unit area.
        dir_rows = {dir_rows, mk_row(OpQuery, 0, 0, 0, 0, 0, 0, 0, 1, 0, StNotFound)};
        dir_rows = {dir_rows, mk_row(OpLoad, 0, 0, 0, 32'h10000, 0, 0, 0, 1, 0, StOk)};
        dir_rows = {dir_rows, mk_row(OpQuery, 0, 0, 0, 0, 0, 0, 0, 1, 32'h8000, StOk)};
        dir_rows = {dir_rows, mk_row(OpLoad, 1, 0, 0, 0, 0, 0, 0, 1, 0, StOk)};
        // Zero weight reached by rounding up a half step.
        dir_rows = {dir_rows, mk_row(OpQuery, 0, 0, 0, 0, 32'h8000, 0, 0, 1, '1, StSat)};
        dir_rows = {dir_rows, mk_row(OpLoad, 2, 0, 0, 1, 0, 0, 0, 1, 0, StOk)};
        dir_rows = {dir_rows, mk_row(OpQuery, 0, 0, 0, 0, 32'h20000, 0, 0, 1,
                                     32'h8000_0000, StOk)};
        dir_rows = {dir_rows, mk_row(OpLoad, 32767, 32767, 32767, '1, 0, 0, 0, 1, 0,
                                     StOk)};
        dir_rows = {dir_rows, mk_row(OpLoad, -32768, -32768, -32768, 32'h10000, '1, '1,
                                     '1, 1, 0, StOk)};
        dir_rows = {dir_rows, mk_row(OpQuery, 0, 0, 0, 0, 32'h7FFF0000, 32'h7FFF0000,
                                     32'h7FFF0000, 0, 0, 0)};
        // Walk leaving the 16-bit lattice never matches.
        dir_rows = {dir_rows, mk_row(OpQuery, 0, 0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                     32'h7FFFFFFF, 0, 0, 0)};
        dir_rows = {dir_rows, mk_row(OpQuery, 0, 0, 0, 0, 32'h80000000, 32'h80000000,
                                     32'h80000000, 0, 0, 0)};
        dir_rows = {dir_rows, mk_row(OpLoad, 0, 0, 0, 32'h20000, 0, 0, 0, 1, 0, StOk)};
        dir_rows = {dir_rows, mk_row(OpQuery, 0, 0, 0, 0, 0, 0, 0, 1, 32'h4000, StOk)};
        dir_rows = {dir_rows, mk_row(OpQuery, 0, 0, 0, 0, 32'hFFFF8000, 32'h4CCC,
                                     32'hB333, 0, 0, 0)};
        dir_rows = {dir_rows, mk_row(OpQuery, 0, 0, 0, 0, 32'hFFFF0000, 32'hFFFF0001,
                                     32'h1, 0, 0, 0)};
        foreach (dir_rows[i]) send_request(dir_rows[i].req, dir_rows[i].typed,
                                           dir_rows[i].ans);
        drain_results();

        // Random phases, each under its own normal and area, extremes first.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_config(-65536, -65536, -65536, '1);
                1: set_config(0, 0, 0, 0);
                2: set_config(65536, 65536, 65536, 32'h0001_0000);
                3: set_config(40000, -12000, 0, 32'h0080_0000);
                default: set_config(int'($urandom_range(0, 131072)) - 65536,
                                    int'($urandom_range(0, 131072)) - 65536,
                                    int'($urandom_range(0, 131072)) - 65536, $urandom);
            endcase
            phase_items = 140;
            while (phase_items > 0) begin
                burst = $urandom_range(1, 20);
                for (int b = 0; b < burst && phase_items > 0; b++) begin
                    send_request(random_request(), 1'b0, no_ans);
                    phase_items--;
                end
                // Drop start for a random gap; zero gaps keep back-to-back streams.
                if ($urandom_range(0, 3) != 0) begin
                    i_start <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge i_clk);
                end
            end
            drain_results();
        end

        repeat (DrainCycles) @(posedge i_clk);
        if (errors == 0 && answers_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

[filelist.f]
+incdir+rtl
rtl/gwwl_pkg.sv
rtl/gwwl_front.sv
rtl/gwwl_div.sv
rtl/gwwl_back.sv
rtl/grid_walk_weight_lookup_unit.sv
bench/grid_walk_weight_lookup_unit_tb.sv
